// ===== design/expiring_duplicate_id_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the duplicate id filter
// concurrent checks sampled on the rising clock edge, off while in reset
// ----------------------------------------------------------------------------
`ifndef EXPIRING_DUPLICATE_ID_FILTER_CORE_ASSERT_SVH
`define EXPIRING_DUPLICATE_ID_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define EDIF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EDIF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/edif_pkg.sv =====
// ----------------------------------------------------------------------------
// edif_pkg
// sizes and result codes shared by the duplicate id filter files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edif_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PURGE_W   = 7;

  typedef logic [ID_W-1:0]     trans_id_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [PURGE_W-1:0]  purge_cnt_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED = 2'd0,
    STATUS_DUP   = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== design/edif_ifs.sv =====
// ----------------------------------------------------------------------------
// edif channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface edif_req_if;
  import edif_pkg::*;

  logic      valid;
  logic      ready;
  trans_id_t trans_id;
  time_t     expires_at;
  time_t     now_time;

  modport source (output valid, output trans_id, output expires_at, output now_time,
                  input ready);
  modport sink   (input valid, input trans_id, input expires_at, input now_time,
                  output ready);
endinterface

interface edif_rsp_if;
  import edif_pkg::*;

  logic       valid;
  logic       ready;
  logic       accepted;
  status_e    status;
  purge_cnt_t purged_count;

  modport source (output valid, output accepted, output status, output purged_count,
                  input ready);
  modport sink   (input valid, input accepted, input status, input purged_count,
                  output ready);
endinterface

`default_nettype wire

// ===== design/expiring_duplicate_id_filter_core.sv =====
// ----------------------------------------------------------------------------
// expiring_duplicate_id_filter_core
// anti-replay id cache: purges expired entries, rejects duplicate ids and
// stores new ids with their expiry in the lowest free slot
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+------------
//  req_i   | in  | trans_id, expires_at, now_time           | valid/ready
//  rsp_o   | out | accepted, status, purged_count           | valid/ready
//
//  the result is registered after one sweep over the id/expiry memory, and the next
//  item is taken once the filter is back in idle; the sweep does one read per cycle
//  through a single expiry compare and id compare unit
//  reset clears the valid bits at once, so no clearing pass is needed
//  req_i.ready is high only while idle; a finished result waits in the output
//  register while the next item is already accepted and swept, and that item's
//  decision waits in the done state until the output register is free
//
`timescale 1ns / 1ps
`default_nettype none

`include "expiring_duplicate_id_filter_core_assert.svh"

module expiring_duplicate_id_filter_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  edif_req_if.sink   req_i,
  edif_rsp_if.source rsp_o
);
  import edif_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // id and expiry store, undefined until a slot is first written
  trans_id_t           id_mem  [CAPACITY];
  logic [TIME_BITS-1:0] exp_mem [CAPACITY];

  // valid bit per slot, cleared by reset
  logic [CAPACITY-1:0] entry_valid_q, entry_valid_d;

  state_e state_q, state_d;

  // latched request
  trans_id_t            id_q, id_d;
  logic [TIME_BITS-1:0] exp_q, exp_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // sweep control: issue side and registered read side
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  trans_id_t            id_rd_q;
  logic [TIME_BITS-1:0] exp_rd_q;

  // sweep results
  logic             dup_q, dup_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  purge_cnt_t       purge_cnt_q, purge_cnt_d;

  // output register
  logic       rsp_valid_q, rsp_valid_d;
  logic       rsp_acc_q, rsp_acc_d;
  status_e    rsp_status_q, rsp_status_d;
  purge_cnt_t rsp_purged_q, rsp_purged_d;

  logic             issue;
  logic [IDX_W-1:0] rd_addr;
  logic             slot_valid;
  logic             hit_expired;
  logic             slot_live;
  logic             done_fire;
  logic             wr_en;

  assign issue   = (state_q == S_SCAN) && (scan_cnt_q < CNT_W'(CAPACITY));
  assign rd_addr = scan_cnt_q[IDX_W-1:0];

  // shared compare unit, one slot per cycle
  assign slot_valid  = entry_valid_q[rd_idx_q];
  assign hit_expired = slot_valid && (exp_rd_q < now_q);
  assign slot_live   = slot_valid && !hit_expired;

  // decision leaves the done state once the output register is free
  assign done_fire = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);
  assign wr_en     = done_fire && !dup_q && free_found_q;

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.accepted     = rsp_acc_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.purged_count = rsp_purged_q;

  always_comb begin
    state_d      = state_q;
    id_d         = id_q;
    exp_d        = exp_q;
    now_d        = now_q;
    scan_cnt_d   = scan_cnt_q;
    rd_vld_d     = issue;
    rd_idx_d     = rd_addr;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    purge_cnt_d  = purge_cnt_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_acc_d    = rsp_acc_q;
    rsp_status_d = rsp_status_q;
    rsp_purged_d = rsp_purged_q;

    // result taken downstream
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          id_d         = req_i.trans_id;
          exp_d        = req_i.expires_at[TIME_BITS-1:0];
          now_d        = req_i.now_time[TIME_BITS-1:0];
          scan_cnt_d   = '0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          purge_cnt_d  = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          // expired slots are freed, counted and become free candidates
          if (hit_expired && (purge_cnt_q != '1)) begin
            purge_cnt_d = purge_cnt_q + PURGE_W'(1);
          end
          if (slot_live && (id_rd_q == id_q)) begin
            dup_d = 1'b1;
          end
          if (!slot_live && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
          if (rd_idx_q == IDX_W'(CAPACITY - 1)) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (done_fire) begin
          rsp_valid_d  = 1'b1;
          rsp_purged_d = purge_cnt_q;
          if (dup_q) begin
            rsp_acc_d    = 1'b0;
            rsp_status_d = STATUS_DUP;
          end else if (!free_found_q) begin
            rsp_acc_d    = 1'b0;
            rsp_status_d = STATUS_FULL;
          end else begin
            rsp_acc_d    = 1'b1;
            rsp_status_d = STATUS_ADDED;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // valid bits: cleared on purge, set on store
  always_comb begin
    entry_valid_d = entry_valid_q;
    if ((state_q == S_SCAN) && rd_vld_q && hit_expired) begin
      entry_valid_d[rd_idx_q] = 1'b0;
    end
    if (wr_en) begin
      entry_valid_d[free_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      entry_valid_q <= '0;
      scan_cnt_q    <= '0;
      rd_vld_q      <= 1'b0;
      dup_q         <= 1'b0;
      free_found_q  <= 1'b0;
      purge_cnt_q   <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_valid_q <= entry_valid_d;
      scan_cnt_q    <= scan_cnt_d;
      rd_vld_q      <= rd_vld_d;
      dup_q         <= dup_d;
      free_found_q  <= free_found_d;
      purge_cnt_q   <= purge_cnt_d;
      rsp_valid_q   <= rsp_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    exp_q        <= exp_d;
    now_q        <= now_d;
    rd_idx_q     <= rd_idx_d;
    free_idx_q   <= free_idx_d;
    rsp_acc_q    <= rsp_acc_d;
    rsp_status_q <= rsp_status_d;
    rsp_purged_q <= rsp_purged_d;
  end

  // store: one read port for the sweep, one write port for the new entry
  always_ff @(posedge clk_i) begin
    id_rd_q  <= id_mem[rd_addr];
    exp_rd_q <= exp_mem[rd_addr];
    if (wr_en) begin
      id_mem[free_idx_q]  <= id_q;
      exp_mem[free_idx_q] <= exp_q;
    end
  end

  // checks
  `EDIF_ASSERT_SAME(a_acc_matches_status, clk_i, rst_ni, rsp_valid_q, (rsp_acc_q == (rsp_status_q == STATUS_ADDED)), "accepted flag disagrees with status")
  `EDIF_ASSERT_NEXT(a_store_sets_valid, clk_i, rst_ni, wr_en, entry_valid_q[$past(free_idx_q)], "stored slot not marked valid")
  `EDIF_ASSERT_NEXT(a_purge_clears_valid, clk_i, rst_ni, (state_q == S_SCAN) && rd_vld_q && hit_expired, !entry_valid_q[$past(rd_idx_q)], "expired slot still valid")
  `EDIF_ASSERT_SAME(a_no_read_outside_scan, clk_i, rst_ni, rd_vld_q, (state_q == S_SCAN), "sweep read outside scan")

endmodule

`default_nettype wire
